>>> src/assert_macros.svh
// Assertion macros used by the top-level RTL file of the stripe pattern generator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an implication holds at every rising edge of clk, outside reset.
`define ASSERT_IMPL(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);

// Checks that a condition leads to a property on the following edge, outside reset.
`define ASSERT_NEXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

>>> src/gcsp_pkg.sv
// Package with types, constants and helper functions of the stripe pattern generator.
`default_nettype none

package gcsp_pkg;

	// Coordinate width of the pixel inputs.
	localparam int COORD_BITS = 12;

	// Widths of the configuration registers.
	localparam int SIZE_W  = 13;
	localparam int LIMIT_W = 4;
	localparam int PAT_W   = 6;
	localparam int NBITS_W = 4;
	localparam int OFF_W   = 12;
	localparam int SUM_W   = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = SIZE_W;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BITS_LIMIT    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_INDEX = 3'd3;

	// Reset values of the registers.
	localparam logic [SIZE_W-1:0]  RESET_WIDTH  = 13'd1024;
	localparam logic [SIZE_W-1:0]  RESET_HEIGHT = 13'd768;
	localparam logic [LIMIT_W-1:0] RESET_LIMIT  = 4'd4;
	localparam logic [PAT_W-1:0]   RESET_INDEX  = 6'd0;

	// Output gray levels.
	localparam logic [7:0] LEVEL_WHITE = 8'd255;
	localparam logic [7:0] LEVEL_BLACK = 8'd0;

	typedef struct packed {
		logic [COORD_BITS-1:0] pixel_row;
		logic [COORD_BITS-1:0] pixel_col;
	} pixel_in_t;

	typedef struct packed {
		logic [7:0] intensity;
		logic       bad_pattern;
	} pixel_out_t;

	// Number of Gray bits for a frame size: bit length of size-1, at least one.
	function automatic logic [NBITS_W-1:0] bits_for(input logic [SIZE_W-1:0] size);
		logic [SIZE_W-1:0]  m;
		logic [NBITS_W-1:0] n;
		m = size - SIZE_W'(1);
		n = NBITS_W'(1);
		if (size > SIZE_W'(1)) begin
			for (int i = 0; i < SIZE_W; i++) begin
				if (m[i]) begin
					n = NBITS_W'(i + 1);
				end
			end
		end
		return n;
	endfunction

	// Centring offset: half the gap between the power of two and the frame size.
	function automatic logic [OFF_W-1:0] center_offset(input logic [SIZE_W-1:0] size,
			input logic [NBITS_W-1:0] nbits);
		logic [SIZE_W:0] pow;
		logic [SIZE_W:0] diff;
		pow  = (SIZE_W+1)'(1) << nbits;
		diff = pow - {1'b0, size};
		return diff[OFF_W:1];
	endfunction

endpackage

`default_nettype wire

>>> src/gray_code_stripe_pattern_pixel.sv
// Top level of the Gray-code stripe pattern pixel generator.
//
//  channel   direction  handshake              payload
//  in        input      in_valid / in_ready    in_data  (pixel_row, pixel_col)
//  out       output     out_valid / out_ready  out_data (intensity, bad_pattern)
//  cfg       input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Each accepted pixel passes an input register and then a result register, with
// the pattern logic between them; one pixel per clock while out_ready is high.
// Reset clears the valid flags and loads the register defaults; cfg_ready is
// always high. A stalled output holds its result while the input register
// still takes one more transaction; in_ready falls only when both are full.
`default_nettype none

`include "assert_macros.svh"

module gray_code_stripe_pattern_pixel (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire gcsp_pkg::pixel_in_t                 in_data,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output gcsp_pkg::pixel_out_t                     out_data,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [gcsp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [gcsp_pkg::CFG_DATA_W-1:0]     cfg_data
);

	// Configuration registers.
	logic [gcsp_pkg::SIZE_W-1:0]  frame_width_q;
	logic [gcsp_pkg::SIZE_W-1:0]  frame_height_q;
	logic [gcsp_pkg::LIMIT_W-1:0] bits_limit_q;
	logic [gcsp_pkg::PAT_W-1:0]   pattern_index_q;

	// Pipeline registers.
	logic                 valid_s1;
	gcsp_pkg::pixel_in_t  pixel_s1;
	gcsp_pkg::pixel_out_t result_s2;
	logic                 valid_s2;

	// Derived frame quantities.
	logic [gcsp_pkg::NBITS_W-1:0] vbits;
	logic [gcsp_pkg::NBITS_W-1:0] hbits;
	logic [gcsp_pkg::OFF_W-1:0]   voff;
	logic [gcsp_pkg::OFF_W-1:0]   hoff;
	logic [gcsp_pkg::NBITS_W-1:0] count;

	// Pattern evaluation.
	logic [gcsp_pkg::SUM_W-1:0]   col_sum;
	logic [gcsp_pkg::SUM_W-1:0]   row_sum;
	logic [gcsp_pkg::SUM_W-1:0]   col_gray;
	logic [gcsp_pkg::SUM_W-1:0]   row_gray;
	logic [gcsp_pkg::PAT_W:0]     col_end;
	logic [gcsp_pkg::PAT_W:0]     row_end;
	logic [gcsp_pkg::PAT_W-1:0]   half_p;
	logic [3:0]                   col_bit;
	logic [4:0]                   row_bit_wide;
	logic [3:0]                   row_bit;
	logic                         hit;
	gcsp_pkg::pixel_out_t         result_d;

	logic advance_s2;
	logic advance_s1;

	assign cfg_ready  = 1'b1;
	assign advance_s2 = !valid_s2 || out_ready;
	assign advance_s1 = !valid_s1 || advance_s2;
	assign in_ready   = advance_s1;
	assign out_valid  = valid_s2;
	assign out_data   = result_s2;

	// Register writes from the configuration port; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q   <= gcsp_pkg::RESET_WIDTH;
			frame_height_q  <= gcsp_pkg::RESET_HEIGHT;
			bits_limit_q    <= gcsp_pkg::RESET_LIMIT;
			pattern_index_q <= gcsp_pkg::RESET_INDEX;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				gcsp_pkg::REG_FRAME_WIDTH: begin
					frame_width_q <= cfg_data;
				end
				gcsp_pkg::REG_FRAME_HEIGHT: begin
					frame_height_q <= cfg_data;
				end
				gcsp_pkg::REG_BITS_LIMIT: begin
					bits_limit_q <= cfg_data[gcsp_pkg::LIMIT_W-1:0];
				end
				gcsp_pkg::REG_PATTERN_INDEX: begin
					pattern_index_q <= cfg_data[gcsp_pkg::PAT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Bit counts, centring offsets and the number of stripe pairs per direction.
	always_comb begin
		vbits = gcsp_pkg::bits_for(frame_width_q);
		hbits = gcsp_pkg::bits_for(frame_height_q);
		voff  = gcsp_pkg::center_offset(frame_width_q, vbits);
		hoff  = gcsp_pkg::center_offset(frame_height_q, hbits);
		count = vbits;
		if (hbits < count) begin
			count = hbits;
		end
		if (bits_limit_q < count) begin
			count = bits_limit_q;
		end
	end

	// Gray code of the centred coordinates and the selected stripe bit.
	always_comb begin
		col_sum  = gcsp_pkg::SUM_W'(pixel_s1.pixel_col) + gcsp_pkg::SUM_W'(voff);
		row_sum  = gcsp_pkg::SUM_W'(pixel_s1.pixel_row) + gcsp_pkg::SUM_W'(hoff);
		col_gray = col_sum ^ (col_sum >> 1);
		row_gray = row_sum ^ (row_sum >> 1);
		half_p   = pattern_index_q >> 1;
		col_end  = (gcsp_pkg::PAT_W+1)'({count, 1'b0}) + (gcsp_pkg::PAT_W+1)'(2);
		row_end  = (gcsp_pkg::PAT_W+1)'({count, 2'b00}) + (gcsp_pkg::PAT_W+1)'(2);
		col_bit  = vbits - half_p[3:0];
		row_bit_wide = 5'(hbits) + 5'(count) - half_p[4:0];
		row_bit  = row_bit_wide[3:0];
		hit      = 1'b0;
		result_d.intensity   = gcsp_pkg::LEVEL_BLACK;
		result_d.bad_pattern = 1'b0;
		if (pattern_index_q < gcsp_pkg::PAT_W'(2)) begin
			// White then black reference frames.
			result_d.intensity = pattern_index_q[0] ? gcsp_pkg::LEVEL_BLACK
				: gcsp_pkg::LEVEL_WHITE;
		end else if ({1'b0, pattern_index_q} < col_end) begin
			// Column stripes, odd indexes inverted.
			hit = col_gray[col_bit] ^ pattern_index_q[0];
			result_d.intensity = hit ? gcsp_pkg::LEVEL_WHITE : gcsp_pkg::LEVEL_BLACK;
		end else if ({1'b0, pattern_index_q} < row_end) begin
			// Row stripes, odd indexes inverted.
			hit = row_gray[row_bit] ^ pattern_index_q[0];
			result_d.intensity = hit ? gcsp_pkg::LEVEL_WHITE : gcsp_pkg::LEVEL_BLACK;
		end else begin
			result_d.bad_pattern = 1'b1;
		end
	end

	// Valid flags of the two stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (advance_s1) begin
				valid_s1 <= in_valid;
			end
			if (advance_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Payload of the two stages.
	always_ff @(posedge clk) begin
		if (advance_s1 && in_valid) begin
			pixel_s1 <= in_data;
		end
		if (advance_s2 && valid_s1) begin
			result_s2 <= result_d;
		end
	end

	// Assertions.
	`ASSERT_NEXT(a_accept_fills_s1, in_valid && in_ready, valid_s1,
		"accepted transaction did not reach the input register")
	`ASSERT_IMPL(a_ready_low_only_full, !in_ready, valid_s1 && valid_s2 && !out_ready,
		"input stalled while a stage was free")
	`ASSERT_IMPL(a_level_binary, out_valid,
		(out_data.intensity == gcsp_pkg::LEVEL_WHITE) ||
		(out_data.intensity == gcsp_pkg::LEVEL_BLACK),
		"intensity is neither black nor white")
	`ASSERT_IMPL(a_bad_is_black, out_valid && out_data.bad_pattern,
		out_data.intensity == gcsp_pkg::LEVEL_BLACK,
		"bad pattern index with nonzero intensity")

endmodule

`default_nettype wire
